FILE: rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// Beep sequence detector package
// Shared widths, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int MAG_BITS_DEF   = 16;
   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 4;

   localparam int THR_BITS   = 16;
   localparam int CONF_BITS  = 4;
   localparam int MS_BITS    = 16;
   localparam int PHASE_BITS = 2;
   localparam int BCNT_BITS  = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [THR_BITS-1:0]  THRESHOLD_RST = 16'd50;
   localparam logic [CONF_BITS-1:0] CONFIRM_RST   = 4'd3;
   localparam logic [MS_BITS-1:0]   MAX_MS_RST    = 16'd1500;
   localparam logic [CONF_BITS-1:0] NEEDED_RST    = 4'd3;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE = 2'd0,
      PH_BEEP = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_LOUD_THRESHOLD   = 3'd0,
      REG_LOUD_TO_CONFIRM  = 3'd1,
      REG_QUIET_TO_CONFIRM = 3'd2,
      REG_MAX_BEEP_MS      = 3'd3,
      REG_MAX_GAP_MS       = 3'd4,
      REG_BEEPS_NEEDED     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [THR_BITS-1:0]  loud_threshold;
      logic [CONF_BITS-1:0] loud_to_confirm;
      logic [CONF_BITS-1:0] quiet_to_confirm;
      logic [MS_BITS-1:0]   max_beep_ms;
      logic [MS_BITS-1:0]   max_gap_ms;
      logic [CONF_BITS-1:0] beeps_needed;
   } cfg_type;

endpackage

FILE: rtl/beep_sequence_detector.sv
// ----------------------------------------------------------------------------
// Beep sequence detector
// Counts confirmed beeps separated by gaps and flags a complete sequence.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per beat: magnitude and millisecond timestamp.
//   rsp_* returns one beat per sample: detected flag, phase after the
//   sample and the running beep count.
//   csr_* writes the six settings (threshold, confirm counts, phase time
//   limits, beeps needed); csr_ready is always high. Write only while idle.
//   An accepted sample lands in the input register; the phase update loads
//   the result register from it once that register is empty or being read,
//   and rsp_tvalid rises with the loaded result. Throughput is one sample
//   per cycle while rsp_tready is high, set by the combinational phase
//   update loop.
//   When rsp_tready is low the result holds and one more sample is taken
//   into the input register; req_tready then drops until the result leaves.
//   Reset clears the phase to idle, all counters and the phase start time,
//   and restores the default settings.
// ----------------------------------------------------------------------------
module beep_sequence_detector #(
   parameter int MAG_BITS   = bsd_pkg::MAG_BITS_DEF,
   parameter int TIME_BITS  = bsd_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = bsd_pkg::COUNT_BITS_DEF,
   localparam int REQ_BITS  = ((MAG_BITS + TIME_BITS + 7) / 8) * 8,
   localparam int RSP_FIELD_BITS = 1 + bsd_pkg::PHASE_BITS + bsd_pkg::BCNT_BITS,
   localparam int RSP_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_BITS-1:0]               req_tdata,  // magnitude, time_ms
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_BITS-1:0]               rsp_tdata,  // detected, phase, beep_count
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bsd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bsd_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int CNT_OUT_BITS =
      (COUNT_BITS > bsd_pkg::BCNT_BITS) ? COUNT_BITS : bsd_pkg::BCNT_BITS;

   bsd_pkg::cfg_type cfg_ff;

   logic                  in_valid_ff;
   logic [MAG_BITS-1:0]   in_mag_ff;
   logic [TIME_BITS-1:0]  in_time_ff;

   bsd_pkg::phase_type    phase_ff;
   logic [COUNT_BITS-1:0] loud_run_ff;
   logic [COUNT_BITS-1:0] quiet_run_ff;
   logic [COUNT_BITS-1:0] beeps_ff;
   logic [TIME_BITS-1:0]  start_ff;

   bsd_pkg::phase_type    phase_in;
   logic [COUNT_BITS-1:0] loud_run_in;
   logic [COUNT_BITS-1:0] quiet_run_in;
   logic [COUNT_BITS-1:0] beeps_in;
   logic [TIME_BITS-1:0]  start_in;
   logic                  detected_in;

   logic                  out_valid_ff;
   logic [RSP_BITS-1:0]   out_data_ff;
   logic [RSP_BITS-1:0]   out_data_in;
   logic [CNT_OUT_BITS-1:0] beeps_wide;
   logic                  advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loud_threshold   <= bsd_pkg::THRESHOLD_RST;
         cfg_ff.loud_to_confirm  <= bsd_pkg::CONFIRM_RST;
         cfg_ff.quiet_to_confirm <= bsd_pkg::CONFIRM_RST;
         cfg_ff.max_beep_ms      <= bsd_pkg::MAX_MS_RST;
         cfg_ff.max_gap_ms       <= bsd_pkg::MAX_MS_RST;
         cfg_ff.beeps_needed     <= bsd_pkg::NEEDED_RST;
      end else if (csr_valid) begin
         case (csr_index)
            bsd_pkg::REG_LOUD_THRESHOLD:   cfg_ff.loud_threshold <= csr_data;
            bsd_pkg::REG_LOUD_TO_CONFIRM:
               cfg_ff.loud_to_confirm <= csr_data[bsd_pkg::CONF_BITS-1:0];
            bsd_pkg::REG_QUIET_TO_CONFIRM:
               cfg_ff.quiet_to_confirm <= csr_data[bsd_pkg::CONF_BITS-1:0];
            bsd_pkg::REG_MAX_BEEP_MS:      cfg_ff.max_beep_ms <= csr_data;
            bsd_pkg::REG_MAX_GAP_MS:       cfg_ff.max_gap_ms <= csr_data;
            bsd_pkg::REG_BEEPS_NEEDED:
               cfg_ff.beeps_needed <= csr_data[bsd_pkg::CONF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mag_ff  <= req_tdata[MAG_BITS-1:0];
         in_time_ff <= req_tdata[MAG_BITS+TIME_BITS-1:MAG_BITS];
      end
   end

   bsd_step #(
      .MAG_BITS   (MAG_BITS),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .cfg           (cfg_ff),
      .magnitude     (in_mag_ff),
      .time_ms       (in_time_ff),
      .phase_cur     (phase_ff),
      .loud_run_cur  (loud_run_ff),
      .quiet_run_cur (quiet_run_ff),
      .beeps_cur     (beeps_ff),
      .start_cur     (start_ff),
      .phase_nxt     (phase_in),
      .loud_run_nxt  (loud_run_in),
      .quiet_run_nxt (quiet_run_in),
      .beeps_nxt     (beeps_in),
      .start_nxt     (start_in),
      .detected      (detected_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bsd_pkg::PH_IDLE;
         loud_run_ff  <= '0;
         quiet_run_ff <= '0;
         beeps_ff     <= '0;
         start_ff     <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         loud_run_ff  <= loud_run_in;
         quiet_run_ff <= quiet_run_in;
         beeps_ff     <= beeps_in;
         start_ff     <= start_in;
      end
   end

   assign beeps_wide  = CNT_OUT_BITS'(beeps_in);
   assign out_data_in = RSP_BITS'({beeps_wide[bsd_pkg::BCNT_BITS-1:0],
                                   phase_in, detected_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

FILE: rtl/bsd_step.sv
// ----------------------------------------------------------------------------
// Beep sequence detector step
// Next phase, run counters, beep count and start time for one sample.
// ----------------------------------------------------------------------------
module bsd_step #(
   parameter int MAG_BITS   = bsd_pkg::MAG_BITS_DEF,
   parameter int TIME_BITS  = bsd_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = bsd_pkg::COUNT_BITS_DEF
) (
   input  bsd_pkg::cfg_type         cfg,
   input  logic [MAG_BITS-1:0]      magnitude,
   input  logic [TIME_BITS-1:0]     time_ms,
   input  bsd_pkg::phase_type       phase_cur,
   input  logic [COUNT_BITS-1:0]    loud_run_cur,
   input  logic [COUNT_BITS-1:0]    quiet_run_cur,
   input  logic [COUNT_BITS-1:0]    beeps_cur,
   input  logic [TIME_BITS-1:0]     start_cur,
   output bsd_pkg::phase_type       phase_nxt,
   output logic [COUNT_BITS-1:0]    loud_run_nxt,
   output logic [COUNT_BITS-1:0]    quiet_run_nxt,
   output logic [COUNT_BITS-1:0]    beeps_nxt,
   output logic [TIME_BITS-1:0]     start_nxt,
   output logic                     detected
);

   localparam int CMP_BITS = (MAG_BITS > bsd_pkg::THR_BITS) ? MAG_BITS : bsd_pkg::THR_BITS;
   localparam int CNT_CMP_BITS =
      (COUNT_BITS > bsd_pkg::CONF_BITS) ? COUNT_BITS : bsd_pkg::CONF_BITS;

   logic                   loud;
   logic [TIME_BITS-1:0]   elapsed;
   logic [TIME_BITS-1:0]   max_beep_ext;
   logic [TIME_BITS-1:0]   max_gap_ext;
   logic [CNT_CMP_BITS-1:0] lconf_ext;
   logic [CNT_CMP_BITS-1:0] qconf_ext;
   logic [CNT_CMP_BITS-1:0] need_ext;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_CMP_BITS-1:0] cext(input logic [COUNT_BITS-1:0] v);
      cext = CNT_CMP_BITS'(v);
   endfunction

   assign loud         = CMP_BITS'(magnitude) > CMP_BITS'(cfg.loud_threshold);
   assign elapsed      = time_ms - start_cur;
   assign max_beep_ext = TIME_BITS'(cfg.max_beep_ms);
   assign max_gap_ext  = TIME_BITS'(cfg.max_gap_ms);
   assign lconf_ext    = CNT_CMP_BITS'(cfg.loud_to_confirm);
   assign qconf_ext    = CNT_CMP_BITS'(cfg.quiet_to_confirm);
   assign need_ext     = CNT_CMP_BITS'(cfg.beeps_needed);

   always_comb begin
      phase_nxt     = phase_cur;
      loud_run_nxt  = loud_run_cur;
      quiet_run_nxt = quiet_run_cur;
      beeps_nxt     = beeps_cur;
      start_nxt     = start_cur;
      detected      = 1'b0;
      case (phase_cur)
         bsd_pkg::PH_BEEP: begin
            if (!loud) begin
               quiet_run_nxt = sat_inc(quiet_run_cur);
               loud_run_nxt  = '0;
            end else begin
               quiet_run_nxt = '0;
            end
            if (cext(quiet_run_nxt) >= qconf_ext) begin
               phase_nxt    = bsd_pkg::PH_GAP;
               start_nxt    = time_ms;
               loud_run_nxt = '0;
            end else if (elapsed > max_beep_ext) begin
               phase_nxt     = bsd_pkg::PH_IDLE;
               loud_run_nxt  = '0;
               quiet_run_nxt = '0;
            end
         end
         bsd_pkg::PH_GAP: begin
            if (loud) begin
               loud_run_nxt  = sat_inc(loud_run_cur);
               quiet_run_nxt = '0;
            end else begin
               loud_run_nxt = '0;
            end
            if (cext(loud_run_nxt) >= lconf_ext) begin
               phase_nxt     = bsd_pkg::PH_BEEP;
               start_nxt     = time_ms;
               beeps_nxt     = sat_inc(beeps_cur);
               quiet_run_nxt = '0;
               if (cext(beeps_nxt) >= need_ext) begin
                  detected     = 1'b1;
                  phase_nxt    = bsd_pkg::PH_IDLE;
                  loud_run_nxt = '0;
               end
            end else if (elapsed > max_gap_ext) begin
               phase_nxt     = bsd_pkg::PH_IDLE;
               loud_run_nxt  = '0;
               quiet_run_nxt = '0;
            end
         end
         default: begin
            phase_nxt = bsd_pkg::PH_IDLE;
            if (loud) begin
               loud_run_nxt  = sat_inc(loud_run_cur);
               quiet_run_nxt = '0;
            end else begin
               loud_run_nxt = '0;
            end
            if (cext(loud_run_nxt) >= lconf_ext) begin
               phase_nxt     = bsd_pkg::PH_BEEP;
               start_nxt     = time_ms;
               beeps_nxt     = COUNT_BITS'(1);
               quiet_run_nxt = '0;
            end
         end
      endcase
   end

endmodule

FILE: tb/beep_sequence_detector_test.sv
// ----------------------------------------------------------------------------
// Beep sequence detector testbench
// Streams timestamped volume samples through the detector and checks every
// status beat against a local model of the idle/beep/gap machine. Runs a
// short directed sequence, then random beep trains, noise and broken trains
// under several register settings, with random input bursts and output
// stalls, including long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module beep_sequence_detector_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_SAMPLES  = 104;
   localparam logic [bsd_pkg::CSR_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [bsd_pkg::CSR_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
   localparam logic [bsd_pkg::BCNT_BITS-1:0] COUNT_SAT = '1;

   typedef struct {
      logic [15:0] magnitude;
      logic [31:0] time_ms;
   } sample_type;

   typedef struct {
      logic                          detected;
      bsd_pkg::phase_type            phase;
      logic [bsd_pkg::BCNT_BITS-1:0] beep_count;
   } status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // magnitude[15:0], time_ms[47:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // detected[0], phase[2:1], beep_count[6:3], pad[7]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [bsd_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [bsd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   beep_sequence_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // model state and settings
   bsd_pkg::cfg_type cfg = '{loud_threshold: bsd_pkg::THRESHOLD_RST,
                             loud_to_confirm: bsd_pkg::CONFIRM_RST,
                             quiet_to_confirm: bsd_pkg::CONFIRM_RST,
                             max_beep_ms: bsd_pkg::MAX_MS_RST,
                             max_gap_ms: bsd_pkg::MAX_MS_RST,
                             beeps_needed: bsd_pkg::NEEDED_RST};
   bsd_pkg::phase_type            cur_phase = bsd_pkg::PH_IDLE;
   logic [bsd_pkg::BCNT_BITS-1:0] loud_run = '0;
   logic [bsd_pkg::BCNT_BITS-1:0] quiet_run = '0;
   logic [bsd_pkg::BCNT_BITS-1:0] beeps_seen = '0;
   logic [31:0]    phase_start_ms = '0;

   sample_type   samples_to_send[$];
   status_type   pending_status[$];
   int        samples_queued = 0;
   int        phase_end = 32'h7FFF_FFFF;
   int        status_seen = 0;
   int        errors = 0;
   logic [31:0] clock_ms = 32'hFFFF_FA00;

   function automatic logic [bsd_pkg::BCNT_BITS-1:0] sat_inc(
      input logic [bsd_pkg::BCNT_BITS-1:0] v);
      return (v == COUNT_SAT) ? v : v + 1'b1;
   endfunction

   task automatic step_detector_state(input sample_type s);
      logic        loud;
      logic [31:0] elapsed;
      status_type  st;
      loud = s.magnitude > cfg.loud_threshold;
      elapsed = s.time_ms - phase_start_ms;
      st.detected = 1'b0;
      case (cur_phase)
         bsd_pkg::PH_BEEP: begin
            if (!loud) begin
               quiet_run = sat_inc(quiet_run);
               loud_run = '0;
            end else begin
               quiet_run = '0;
            end
            if (quiet_run >= cfg.quiet_to_confirm) begin
               cur_phase = bsd_pkg::PH_GAP;
               phase_start_ms = s.time_ms;
               loud_run = '0;
            end else if (elapsed > {16'd0, cfg.max_beep_ms}) begin
               cur_phase = bsd_pkg::PH_IDLE;
               loud_run = '0;
               quiet_run = '0;
            end
         end
         bsd_pkg::PH_GAP: begin
            if (loud) begin
               loud_run = sat_inc(loud_run);
               quiet_run = '0;
            end else begin
               loud_run = '0;
            end
            if (loud_run >= cfg.loud_to_confirm) begin
               cur_phase = bsd_pkg::PH_BEEP;
               phase_start_ms = s.time_ms;
               beeps_seen = sat_inc(beeps_seen);
               quiet_run = '0;
               if (beeps_seen >= cfg.beeps_needed) begin
                  st.detected = 1'b1;
                  cur_phase = bsd_pkg::PH_IDLE;
                  loud_run = '0;
                  quiet_run = '0;
               end
            end else if (elapsed > {16'd0, cfg.max_gap_ms}) begin
               cur_phase = bsd_pkg::PH_IDLE;
               loud_run = '0;
               quiet_run = '0;
            end
         end
         default: begin
            cur_phase = bsd_pkg::PH_IDLE;
            if (loud) begin
               loud_run = sat_inc(loud_run);
               quiet_run = '0;
            end else begin
               loud_run = '0;
            end
            if (loud_run >= cfg.loud_to_confirm) begin
               cur_phase = bsd_pkg::PH_BEEP;
               phase_start_ms = s.time_ms;
               beeps_seen = 4'd1;
               quiet_run = '0;
            end
         end
      endcase
      st.phase = cur_phase;
      st.beep_count = beeps_seen;
      pending_status.push_back(st);
   endtask

   // ---------------------------------------------------------------- driver
   sample_type offered;
   int      burst_left = 1;
   int      gap_left = 0;

   always @(posedge clock) begin : drive_samples
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready) begin
            step_detector_state(offered);
         end
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (samples_to_send.size() > 0) begin
            offered = samples_to_send.pop_front();
            next_valid = 1'b1;
            req_tdata <= {offered.time_ms, offered.magnitude};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // --------------------------------------------------------------- monitor
   int   cycle_n = 0;
   int   stall_mode = 0;
   int   hold_left = 0;

   always @(posedge clock) begin : check_status
      status_type want;
      logic    next_ready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            status_seen++;
            if (pending_status.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_status.pop_front();
               if (rsp_tdata[0] !== want.detected) begin
                  $display("%0t: detected expected %0d actual %0d",
                           $time, want.detected, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[2:1] !== want.phase) begin
                  $display("%0t: phase expected %0d actual %0d",
                           $time, want.phase, rsp_tdata[2:1]);
                  errors++;
               end
               if (rsp_tdata[6:3] !== want.beep_count) begin
                  $display("%0t: beep_count expected %0d actual %0d",
                           $time, want.beep_count, rsp_tdata[6:3]);
                  errors++;
               end
            end
            if (status_seen % 300 == 150) hold_left = HOLD_CYCLES;
         end
         cycle_n++;
         if (cycle_n % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            case (stall_mode)
               0: next_ready = 1'b1;
               1: next_ready = cycle_n[0];
               2: next_ready = ($urandom_range(0, 9) < 7);
               default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   // -------------------------------------------------------------- watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic add_sample(input int mag, input logic [31:0] dt);
      sample_type s;
      if (samples_queued >= phase_end) return;
      clock_ms += dt;
      s.magnitude = mag[15:0];
      s.time_ms = clock_ms;
      samples_to_send.push_back(s);
      samples_queued++;
   endtask

   function automatic int loud_mag();
      if (cfg.loud_threshold == 16'hFFFF) return $urandom_range(0, 65535);
      return $urandom_range(int'(cfg.loud_threshold) + 1, 65535);
   endfunction

   function automatic int quiet_mag();
      return $urandom_range(0, int'(cfg.loud_threshold));
   endfunction

   task automatic write_reg(input logic [bsd_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [bsd_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         bsd_pkg::REG_LOUD_THRESHOLD:   cfg.loud_threshold = val;
         bsd_pkg::REG_LOUD_TO_CONFIRM:
            cfg.loud_to_confirm = val[bsd_pkg::CONF_BITS-1:0];
         bsd_pkg::REG_QUIET_TO_CONFIRM:
            cfg.quiet_to_confirm = val[bsd_pkg::CONF_BITS-1:0];
         bsd_pkg::REG_MAX_BEEP_MS:      cfg.max_beep_ms = val;
         bsd_pkg::REG_MAX_GAP_MS:       cfg.max_gap_ms = val;
         bsd_pkg::REG_BEEPS_NEEDED:
            cfg.beeps_needed = val[bsd_pkg::CONF_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int thr, input int loud_n, input int quiet_n,
                                input int beep_ms, input int gap_ms, input int needed);
      write_reg(bsd_pkg::REG_LOUD_THRESHOLD, thr[15:0]);
      write_reg(bsd_pkg::REG_LOUD_TO_CONFIRM, loud_n[15:0]);
      write_reg(bsd_pkg::REG_QUIET_TO_CONFIRM, quiet_n[15:0]);
      write_reg(bsd_pkg::REG_MAX_BEEP_MS, beep_ms[15:0]);
      write_reg(bsd_pkg::REG_MAX_GAP_MS, gap_ms[15:0]);
      write_reg(bsd_pkg::REG_BEEPS_NEEDED, needed[15:0]);
      if ($urandom_range(0, 1)) write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
      else write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
   endtask

   task automatic wait_drained();
      while (samples_to_send.size() != 0 || status_seen < samples_queued)
         @(posedge clock);
   endtask

   // a beep train with random content; broken trains flip loudness or jump time
   task automatic queue_train(input bit broken);
      int beeps, n_loud, n_quiet, span, step_cap, jump;
      span = (cfg.max_beep_ms < cfg.max_gap_ms) ? cfg.max_beep_ms : cfg.max_gap_ms;
      step_cap = span / 34;
      if (step_cap > 80) step_cap = 80;
      jump = span + $urandom_range(0, 2);
      beeps = $urandom_range(1, int'(cfg.beeps_needed) + 1);
      for (int b = 0; b < beeps; b++) begin
         n_loud = ((cfg.loud_to_confirm == 0) ? 1 : cfg.loud_to_confirm) + $urandom_range(0, 1);
         n_quiet = ((cfg.quiet_to_confirm == 0) ? 1 : cfg.quiet_to_confirm) + $urandom_range(0, 1);
         for (int i = 0; i < n_loud + n_quiet; i++) begin
            if (broken && $urandom_range(0, 11) == 0) begin
               if ($urandom_range(0, 1)) add_sample((i < n_loud) ? quiet_mag() : loud_mag(),
                                                    $urandom_range(0, step_cap));
               else add_sample((i < n_loud) ? loud_mag() : quiet_mag(), jump);
            end else begin
               add_sample((i < n_loud) ? loud_mag() : quiet_mag(), $urandom_range(0, step_cap));
            end
         end
      end
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: add_sample($urandom_range(0, 65535), 0);
            1: add_sample($urandom_range(0, 65535), $urandom_range(1, 3000));
            default: add_sample($urandom_range(0, 65535), $urandom);
         endcase
      end
   endtask

   task automatic run_random_phase();
      phase_end = samples_queued + PHASE_SAMPLES;
      while (samples_queued < phase_end) begin
         case ($urandom_range(0, 9))
            7, 8: queue_train(1'b1);
            9: queue_noise();
            default: queue_train(1'b0);
         endcase
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // defaults: thresholds at the edge, a full three-beep train, count held
      // in idle, beep timeout exactly at the limit and one past it, time wrap
      add_sample(0, 10);
      add_sample(50, 10);
      add_sample(51, 10);
      add_sample(65535, 10);
      add_sample(51, 10);
      repeat (3) add_sample(0, 10);
      repeat (3) add_sample(60000, 10);
      repeat (3) add_sample(0, 10);
      repeat (3) add_sample(51, 10);
      repeat (3) add_sample(200, 10);
      add_sample(200, 1500);
      add_sample(200, 1);
      wait_drained();

      apply_setting(1000, 1, 1, 200, 200, 2);
      run_random_phase();
      apply_setting(0, 0, 0, 0, 0, 0);
      run_random_phase();
      apply_setting(65534, 15, 15, 65535, 65535, 15);
      run_random_phase();
      apply_setting(65535, 3, 3, 1500, 1500, 3);
      run_random_phase();
      apply_setting(30000, 2, 5, 100, 800, 1);
      run_random_phase();
      repeat (3) begin
         apply_setting($urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 15));
         run_random_phase();
      end

      repeat (8) @(posedge clock);
      if (pending_status.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_status.size());
         errors++;
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: beep_sequence_detector.f
rtl/bsd_pkg.sv
rtl/bsd_step.sv
rtl/beep_sequence_detector.sv
tb/beep_sequence_detector_test.sv
